// ===== rtl/wmpt_pkg.sv =====
// shared types and constants of the windowed minimum pressure tracker
package wmpt_pkg;

	localparam int unsigned PRES_W = 31;
	localparam int unsigned TEMP_W = 16;
	localparam int unsigned CNT_W  = 16;
	localparam int unsigned SUM_W  = 32;

	localparam logic [PRES_W-1:0] EMPTY_MIN = {PRES_W{1'b1}};
	localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0]  TPW_RESET = 16'd60;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_FAIL   = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOOK,
		ST_MODIFY,
		ST_TICK,
		ST_SCAN,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic              start;
		logic              neg;
		logic [SUM_W-1:0]  magnitude;
		logic [CNT_W-1:0]  divisor;
	} div_req_t;

endpackage

// ===== rtl/windowed_minimum_pressure_tracker_core.sv =====
// Windowed minimum pressure tracker: tracks the lowest pressure over a sliding
// span of WINDOWS sub-windows, each ticks_per_window ticks long, plus the last
// sample, a truncated temperature mean and a saturating failure count. One
// result item per input item. Items are handled one at a time. When a sample
// or a failed reading closes a sub-window, the sub-window minima memory is
// rescanned one entry per cycle. The mean comes from a 32-bit bit-serial
// divider, which is skipped when the mean is empty. The next item can be
// accepted from the cycle after the result is registered. The result waits in
// an output register, so the next item may be accepted while it is still
// held. A result still held there stalls the following one in its last
// cycle. The minima memory needs no clearing pass after reset.
module windowed_minimum_pressure_tracker_core #(
	parameter int unsigned WINDOWS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [15:0]                        cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         operation,
	input  logic [wmpt_pkg::PRES_W-1:0]        pressure_sample,
	input  logic signed [wmpt_pkg::TEMP_W-1:0] temperature_sample,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [wmpt_pkg::PRES_W-1:0]        overall_minimum,
	output logic [wmpt_pkg::PRES_W-1:0]        last_pressure,
	output logic signed [wmpt_pkg::TEMP_W-1:0] last_temperature,
	output logic signed [wmpt_pkg::TEMP_W-1:0] mean_temperature,
	output logic                               mean_valid,
	output logic [wmpt_pkg::CNT_W-1:0]         error_total
);

	localparam int unsigned PTR_W = $clog2(WINDOWS);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOWS - 1);
	localparam logic [PTR_W:0]   SCAN_END = (PTR_W + 1)'(WINDOWS);

	wmpt_pkg::state_t state_q, state_d;

	logic [wmpt_pkg::CNT_W-1:0]  tpw_q;
	logic [wmpt_pkg::PRES_W-1:0] p_q;
	logic [wmpt_pkg::TEMP_W-1:0] t_q;
	logic [PTR_W-1:0]            ptr_q;
	logic [wmpt_pkg::CNT_W-1:0]  tick_q;
	logic [wmpt_pkg::PRES_W-1:0] lowest_q;
	logic [wmpt_pkg::PRES_W-1:0] recent_p_q;
	logic [wmpt_pkg::TEMP_W-1:0] recent_t_q;
	logic [wmpt_pkg::SUM_W-1:0]  sum_q;
	logic [wmpt_pkg::CNT_W-1:0]  count_q;
	logic [wmpt_pkg::CNT_W-1:0]  fail_q;
	logic [wmpt_pkg::TEMP_W-1:0] mean_q;
	logic [PTR_W:0]              scan_cnt_q;
	logic                        scan_pend_q;
	logic [wmpt_pkg::PRES_W-1:0] scan_best_q;

	logic                        out_valid_q;
	logic [wmpt_pkg::PRES_W-1:0] out_min_q;
	logic [wmpt_pkg::PRES_W-1:0] out_p_q;
	logic [wmpt_pkg::TEMP_W-1:0] out_t_q;
	logic [wmpt_pkg::TEMP_W-1:0] out_mean_q;
	logic                        out_mv_q;
	logic [wmpt_pkg::CNT_W-1:0]  out_err_q;

	logic                        in_fire;
	logic                        out_free;
	logic                        scan_issue;
	logic [wmpt_pkg::CNT_W-1:0]  tick_next;
	logic                        win_end;
	logic [PTR_W-1:0]            ptr_next;
	logic                        mem_wr_en;
	logic                        mem_clr_en;
	logic [PTR_W-1:0]            mem_rd_addr;
	logic [wmpt_pkg::PRES_W-1:0] mem_rd_data;
	wmpt_pkg::div_req_t          div_req;
	logic                        div_done;
	logic [wmpt_pkg::TEMP_W-1:0] div_quot;

	assign cfg_ready  = 1'b1;
	assign in_ready   = (state_q == wmpt_pkg::ST_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign scan_issue = (state_q == wmpt_pkg::ST_SCAN) && (scan_cnt_q != SCAN_END);
	assign tick_next  = tick_q + 1'b1;
	assign win_end    = (tick_next >= tpw_q) || (tick_next == '0);
	assign ptr_next   = (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
	assign mem_wr_en  = (state_q == wmpt_pkg::ST_MODIFY) && (p_q < mem_rd_data);
	assign mem_clr_en = (state_q == wmpt_pkg::ST_TICK) && win_end;
	assign mem_rd_addr = scan_issue ? scan_cnt_q[PTR_W-1:0] : ptr_q;

	assign div_req.start     = (state_q == wmpt_pkg::ST_DIV_START) && (count_q != '0);
	assign div_req.neg       = sum_q[wmpt_pkg::SUM_W-1];
	assign div_req.magnitude = sum_q[wmpt_pkg::SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
	assign div_req.divisor   = count_q;

	wmpt_minmem #(
		.WINDOWS (WINDOWS),
		.PTR_W   (PTR_W)
	) u_minmem (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (mem_wr_en),
		.wr_addr  (ptr_q),
		.wr_data  (p_q),
		.clr_en   (mem_clr_en),
		.clr_addr (ptr_next),
		.rd_addr  (mem_rd_addr),
		.rd_data  (mem_rd_data)
	);

	wmpt_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wmpt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wmpt_pkg::ST_IDLE: begin
				if (in_fire) begin
					unique case (wmpt_pkg::op_t'(operation))
						wmpt_pkg::OP_SAMPLE: state_d = wmpt_pkg::ST_LOOK;
						wmpt_pkg::OP_FAIL:   state_d = wmpt_pkg::ST_TICK;
						wmpt_pkg::OP_CLEAR:  state_d = wmpt_pkg::ST_DIV_START;
						wmpt_pkg::OP_NONE:   state_d = wmpt_pkg::ST_DIV_START;
						default:             state_d = wmpt_pkg::ST_DIV_START;
					endcase
				end
			end
			wmpt_pkg::ST_LOOK:   state_d = wmpt_pkg::ST_MODIFY;
			wmpt_pkg::ST_MODIFY: state_d = wmpt_pkg::ST_TICK;
			wmpt_pkg::ST_TICK: begin
				state_d = win_end ? wmpt_pkg::ST_SCAN : wmpt_pkg::ST_DIV_START;
			end
			wmpt_pkg::ST_SCAN: begin
				if (!scan_issue && !scan_pend_q) begin
					state_d = wmpt_pkg::ST_DIV_START;
				end
			end
			wmpt_pkg::ST_DIV_START: begin
				state_d = (count_q != '0) ? wmpt_pkg::ST_DIV_WAIT : wmpt_pkg::ST_OUT;
			end
			wmpt_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = wmpt_pkg::ST_OUT;
				end
			end
			wmpt_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = wmpt_pkg::ST_IDLE;
				end
			end
			default: state_d = wmpt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpw_q       <= wmpt_pkg::TPW_RESET;
			ptr_q       <= '0;
			tick_q      <= '0;
			lowest_q    <= wmpt_pkg::EMPTY_MIN;
			recent_p_q  <= '0;
			recent_t_q  <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			fail_q      <= '0;
			scan_cnt_q  <= '0;
			scan_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tpw_q <= cfg_data;
			end
			scan_pend_q <= scan_issue;
			if (scan_issue) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				wmpt_pkg::ST_IDLE: begin
					if (in_fire) begin
						if (wmpt_pkg::op_t'(operation) == wmpt_pkg::OP_FAIL) begin
							if (fail_q != wmpt_pkg::CNT_MAX) begin
								fail_q <= fail_q + 1'b1;
							end
						end
						if (wmpt_pkg::op_t'(operation) == wmpt_pkg::OP_CLEAR) begin
							sum_q   <= '0;
							count_q <= '0;
						end
					end
				end
				wmpt_pkg::ST_MODIFY: begin
					recent_p_q <= p_q;
					recent_t_q <= t_q;
					if (p_q < mem_rd_data && p_q < lowest_q) begin
						lowest_q <= p_q;
					end
					if (count_q != wmpt_pkg::CNT_MAX) begin
						sum_q   <= sum_q + {{(wmpt_pkg::SUM_W - wmpt_pkg::TEMP_W){t_q[15]}}, t_q};
						count_q <= count_q + 1'b1;
					end
				end
				wmpt_pkg::ST_TICK: begin
					if (win_end) begin
						tick_q     <= '0;
						ptr_q      <= ptr_next;
						scan_cnt_q <= '0;
					end else begin
						tick_q <= tick_next;
					end
				end
				wmpt_pkg::ST_SCAN: begin
					if (!scan_issue && !scan_pend_q) begin
						lowest_q <= scan_best_q;
					end
				end
				wmpt_pkg::ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			p_q  <= pressure_sample;
			t_q  <= temperature_sample;
		end
		if (state_q == wmpt_pkg::ST_TICK) begin
			scan_best_q <= wmpt_pkg::EMPTY_MIN;
		end else if (scan_pend_q && mem_rd_data < scan_best_q) begin
			scan_best_q <= mem_rd_data;
		end
		if (state_q == wmpt_pkg::ST_DIV_START) begin
			mean_q <= '0;
		end else if (state_q == wmpt_pkg::ST_DIV_WAIT && div_done) begin
			mean_q <= div_quot;
		end
		if (state_q == wmpt_pkg::ST_OUT && out_free) begin
			out_min_q  <= lowest_q;
			out_p_q    <= recent_p_q;
			out_t_q    <= recent_t_q;
			out_mean_q <= mean_q;
			out_mv_q   <= (count_q != '0);
			out_err_q  <= fail_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign overall_minimum  = out_min_q;
	assign last_pressure    = out_p_q;
	assign last_temperature = out_t_q;
	assign mean_temperature = out_mean_q;
	assign mean_valid       = out_mv_q;
	assign error_total      = out_err_q;

endmodule

// ===== rtl/wmpt_minmem.sv =====
// sub-window minima memory with per-entry valid bits, registered read
module wmpt_minmem #(
	parameter int unsigned WINDOWS = 8,
	parameter int unsigned PTR_W   = 3
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [PTR_W-1:0]            wr_addr,
	input  logic [wmpt_pkg::PRES_W-1:0] wr_data,
	input  logic                        clr_en,
	input  logic [PTR_W-1:0]            clr_addr,
	input  logic [PTR_W-1:0]            rd_addr,
	output logic [wmpt_pkg::PRES_W-1:0] rd_data
);

	logic [wmpt_pkg::PRES_W-1:0] mem [WINDOWS];
	logic [WINDOWS-1:0]          vld_q;
	logic [wmpt_pkg::PRES_W-1:0] rd_data_q;
	logic                        rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (clr_en) begin
				vld_q[clr_addr] <= 1'b0;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : wmpt_pkg::EMPTY_MIN;

endmodule

// ===== rtl/wmpt_divider.sv =====
// iterative restoring divider for the temperature mean, one quotient bit per cycle
module wmpt_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  wmpt_pkg::div_req_t          req,
	output logic                        done,
	output logic [wmpt_pkg::TEMP_W-1:0] quotient
);

	localparam int unsigned STEP_W = $clog2(wmpt_pkg::SUM_W);

	logic                         busy_q;
	logic                         done_q;
	logic [STEP_W-1:0]            step_q;
	logic                         neg_q;
	logic [wmpt_pkg::CNT_W-1:0]   dvs_q;
	logic [wmpt_pkg::CNT_W-1:0]   rem_q;
	logic [wmpt_pkg::SUM_W-1:0]   quo_q;
	logic [wmpt_pkg::CNT_W:0]     rem_sh;
	logic [wmpt_pkg::CNT_W+1:0]   diff;
	logic                         ge;
	logic [wmpt_pkg::TEMP_W-1:0]  q_low;

	assign rem_sh = {rem_q, quo_q[wmpt_pkg::SUM_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign ge     = ~diff[wmpt_pkg::CNT_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(wmpt_pkg::SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.neg;
			dvs_q <= req.divisor;
			rem_q <= '0;
			quo_q <= req.magnitude;
		end else if (busy_q) begin
			rem_q <= ge ? diff[wmpt_pkg::CNT_W-1:0] : rem_sh[wmpt_pkg::CNT_W-1:0];
			quo_q <= {quo_q[wmpt_pkg::SUM_W-2:0], ge};
		end
	end

	assign q_low    = quo_q[wmpt_pkg::TEMP_W-1:0];
	assign quotient = neg_q ? (~q_low + 1'b1) : q_low;
	assign done     = done_q;

endmodule
